FILE: rtl/core/polygon_plane_split_core_macros.svh
// ----------------------------------------------------------------------------
// Polygon plane split assertion macros
// Shared concurrent assertion forms for the split core checkers.
// ----------------------------------------------------------------------------
`ifndef POLYGON_PLANE_SPLIT_CORE_MACROS_SVH
`define POLYGON_PLANE_SPLIT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// Polygon plane split package
// Shared types, codes and widths of the polygon plane split core.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int COORD_W = 32;
   localparam int NORM_W  = 18;
   localparam int EPS_W   = 31;
   localparam int DIST_W  = 52;
   localparam int FRAC_W  = 32;
   localparam int CSR_W   = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [NORM_W-1:0] ONE_Q16     = 18'sd65536;
   localparam logic signed [NORM_W-1:0] MINUS_ONE_Q16 = -18'sd65536;

   localparam logic [CSR_W-1:0] CSR_NORMAL_X  = 3'd0;
   localparam logic [CSR_W-1:0] CSR_NORMAL_Y  = 3'd1;
   localparam logic [CSR_W-1:0] CSR_NORMAL_Z  = 3'd2;
   localparam logic [CSR_W-1:0] CSR_PLANE_D   = 3'd3;
   localparam logic [CSR_W-1:0] CSR_EPSILON   = 3'd4;

   typedef enum logic [1:0] {
      SIDE_AHEAD  = 2'd0,
      SIDE_BEHIND = 2'd1,
      SIDE_ON     = 2'd2
   } side_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      side;
      logic                      status;
   } result_type;

   typedef struct packed {
      logic [DIST_W-1:0] num;
      logic [DIST_W:0]   den;
   } div_req_type;

endpackage

FILE: rtl/core/pps_frac_div.sv
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider giving num/den as a Q0.32 fraction, one bit per cycle.
// ----------------------------------------------------------------------------
module pps_frac_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  pps_pkg::div_req_type         req,
   output logic                         done,
   output logic [pps_pkg::FRAC_W-1:0]   quot
);

   localparam int REM_W = pps_pkg::DIST_W + 2;
   localparam int CNT_W = $clog2(pps_pkg::FRAC_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        zero_ff, zero_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [pps_pkg::DIST_W:0]    den_ff, den_in;
   logic [pps_pkg::FRAC_W-1:0]  q_ff, q_in;
   logic [REM_W-1:0]            rem_sh;

   assign rem_sh = {rem_ff[REM_W-2:0], 1'b0};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {2'b00, req.num};
         den_in  = req.den;
         q_in    = '0;
         zero_in = (req.den == '0) || ({1'b0, req.num} >= req.den);
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            q_in   = {q_ff[pps_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[pps_pkg::FRAC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(pps_pkg::FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
   end

   assign done = done_ff;
   assign quot = zero_ff ? '0 : q_ff;

endmodule

FILE: rtl/core/polygon_plane_split_core.sv
// ----------------------------------------------------------------------------
// Polygon plane split core
// Splits a convex Q16.16 polygon by a plane into front and back polygons.
// ----------------------------------------------------------------------------
// Vertices are taken one per cycle while the core is idle and are written to
// the vertex memory. The transfer that carries last_vertex starts a
// classification pass over the stored vertices, unless the memory overflowed.
// The emit pass then walks the front and the back polygon, or only one when no
// vertex lies on the other side, and sends each crossing edge through the
// bit-serial fraction divider and the shared interpolation multiplier. Results
// leave through an output register, so a stalled result channel does not stop
// the work until a second result is waiting. A new polygon is accepted once
// the last result of the previous one has been handed to the output register.
module polygon_plane_split_core #(
   parameter int MAX_VERTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pps_pkg::COORD_W-1:0]   req_vertex_x,
   input  logic signed [pps_pkg::COORD_W-1:0]   req_vertex_y,
   input  logic signed [pps_pkg::COORD_W-1:0]   req_vertex_z,
   input  logic                                 req_last_vertex,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pps_pkg::COORD_W-1:0]   rsp_out_x,
   output logic signed [pps_pkg::COORD_W-1:0]   rsp_out_y,
   output logic signed [pps_pkg::COORD_W-1:0]   rsp_out_z,
   output logic                                 rsp_which_side,
   output logic                                 rsp_status,
   output logic                                 rsp_last_result,
   input  logic                                 csr_write_enable,
   input  logic [pps_pkg::CSR_W-1:0]            csr_index,
   input  logic [pps_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int IW  = $clog2(MAX_VERTS);
   localparam int CW  = $clog2(MAX_VERTS + 1);
   localparam int KW  = CW + 3;
   localparam int CRW = pps_pkg::COORD_W;
   localparam int DW  = pps_pkg::DIST_W;
   localparam int PW  = pps_pkg::NORM_W + CRW;
   localparam int VW  = 3 * CRW;
   localparam int SW  = DW + 2;

   typedef enum logic [4:0] {
      S_IDLE, S_CRD, S_CCAP, S_CMX, S_CMY, S_CMZ, S_CSUM, S_CCLS, S_DECIDE,
      S_WRD_I, S_WCAP_I, S_WCAP_J, S_WVTX, S_WCHK, S_WDIV, S_WMUL, S_WCRD,
      S_WPUSH, S_WNEXT, S_FIN
   } state_type;

   state_type state_ff;

   logic signed [pps_pkg::NORM_W-1:0]  nx_ff, ny_ff, nz_ff;
   logic signed [CRW-1:0]              pd_ff;
   logic [pps_pkg::EPS_W-1:0]          eps_ff;

   logic [VW-1:0]  vtx_mem [MAX_VERTS];
   logic [SW-1:0]  dist_mem [MAX_VERTS];
   logic [VW-1:0]  vtx_rd_ff;
   logic [SW-1:0]  dist_rd_ff;
   logic [IW-1:0]  rd_addr;
   logic           dist_we;
   logic [SW-1:0]  dist_wdata;

   logic [CW-1:0]  cnt_ff, cnt_m1;
   logic           ovf_ff;
   logic [IW-1:0]  idx_ff, idx_last, idx_next;
   logic [CW-1:0]  nf_ff, nb_ff, ncr_ff;
   pps_pkg::side_type prev_side_ff, first_side_ff, cls_side;

   logic signed [PW-1:0]  prod_ff;
   logic signed [DW-1:0]  acc_ff;
   logic signed [DW-1:0]  eps_pos, eps_neg, pd_shift;

   logic signed [CRW-1:0] pix_ff, piy_ff, piz_ff, pjx_ff, pjy_ff, pjz_ff;
   logic signed [DW-1:0]  pid_ff, pjd_ff;
   pps_pkg::side_type     si_ff, sj_ff;
   logic                  whole_ff, side_sel_ff;
   logic                  vtx_cond, cross_cond;

   pps_pkg::div_req_type  div_req;
   logic                  div_start, div_done;
   logic [pps_pkg::FRAC_W-1:0] div_quot, frac_ff;
   logic [DW-1:0]         mag_i, mag_j;

   logic [1:0]            axis_ff;
   logic signed [pps_pkg::NORM_W-1:0] ax_n;
   logic signed [CRW-1:0] ax_p1, ax_p2, ax_p1_ff, neg_pd;
   logic signed [CRW:0]   ax_diff;
   logic [CRW:0]          ax_mag;
   logic [2*CRW:0]        mprod_ff;
   logic                  msign_ff;
   logic signed [pps_pkg::NORM_W-1:0] mnorm_ff;
   logic [CRW:0]          t_val;
   logic signed [CRW+1:0] mid_sum;
   logic signed [CRW-1:0] mid_val;
   logic signed [CRW-1:0] midx_ff, midy_ff, midz_ff;

   pps_pkg::result_type   pend_ff, rsp_ff, new_res, err_res;
   logic                  pend_valid_ff, rsp_valid_ff, rsp_last_ff;
   logic                  out_free, can_produce;

   pps_frac_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign cnt_m1   = cnt_ff - CW'(1);
   assign idx_last = cnt_m1[IW-1:0];
   assign idx_next = (idx_ff == idx_last) ? '0 : idx_ff + IW'(1);

   assign eps_pos  = $signed({5'b0, eps_ff, 16'b0});
   assign eps_neg  = -eps_pos;
   assign pd_shift = $signed({{4{pd_ff[CRW-1]}}, pd_ff, 16'b0});

   always_comb begin
      if (acc_ff > eps_pos) begin
         cls_side = pps_pkg::SIDE_AHEAD;
      end else if (acc_ff < eps_neg) begin
         cls_side = pps_pkg::SIDE_BEHIND;
      end else begin
         cls_side = pps_pkg::SIDE_ON;
      end
   end

   assign dist_we    = (state_ff == S_CCLS);
   assign dist_wdata = {cls_side, acc_ff};

   always_comb begin
      rd_addr = idx_ff;
      if (state_ff == S_WCAP_I) begin
         rd_addr = idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready && (cnt_ff < CW'(MAX_VERTS))) begin
         vtx_mem[cnt_ff[IW-1:0]] <= {req_vertex_x, req_vertex_y, req_vertex_z};
      end
      vtx_rd_ff <= vtx_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[idx_ff] <= dist_wdata;
      end
      dist_rd_ff <= dist_mem[rd_addr];
   end

   assign vtx_cond   = whole_ff || (si_ff == pps_pkg::SIDE_ON) ||
                       (si_ff[0] == side_sel_ff && si_ff != pps_pkg::SIDE_ON);
   assign cross_cond = !whole_ff && (si_ff != pps_pkg::SIDE_ON) &&
                       (sj_ff != pps_pkg::SIDE_ON) && (si_ff != sj_ff);

   assign mag_i       = pid_ff[DW-1] ? DW'(-pid_ff) : DW'(pid_ff);
   assign mag_j       = pjd_ff[DW-1] ? DW'(-pjd_ff) : DW'(pjd_ff);
   assign div_req.num = mag_i;
   assign div_req.den = {1'b0, mag_i} + {1'b0, mag_j};
   assign div_start   = (state_ff == S_WCHK) && cross_cond;

   always_comb begin
      case (axis_ff)
         2'd0:    begin ax_n = nx_ff; ax_p1 = pix_ff; ax_p2 = pjx_ff; end
         2'd1:    begin ax_n = ny_ff; ax_p1 = piy_ff; ax_p2 = pjy_ff; end
         default: begin ax_n = nz_ff; ax_p1 = piz_ff; ax_p2 = pjz_ff; end
      endcase
   end

   assign ax_diff = $signed({ax_p2[CRW-1], ax_p2}) - $signed({ax_p1[CRW-1], ax_p1});
   assign ax_mag  = ax_diff[CRW] ? (CRW+1)'(-ax_diff) : (CRW+1)'(ax_diff);
   assign t_val   = mprod_ff[2*CRW:CRW];
   assign mid_sum = msign_ff ? ($signed({{2{ax_p1_ff[CRW-1]}}, ax_p1_ff}) -
                                $signed({1'b0, t_val}))
                             : ($signed({{2{ax_p1_ff[CRW-1]}}, ax_p1_ff}) +
                                $signed({1'b0, t_val}));
   assign neg_pd  = (pd_ff == {1'b1, {(CRW-1){1'b0}}}) ? {1'b0, {(CRW-1){1'b1}}} : -pd_ff;

   always_comb begin
      if (mnorm_ff == pps_pkg::ONE_Q16) begin
         mid_val = pd_ff;
      end else if (mnorm_ff == pps_pkg::MINUS_ONE_Q16) begin
         mid_val = neg_pd;
      end else begin
         mid_val = mid_sum[CRW-1:0];
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign can_produce = !pend_valid_ff || out_free;

   always_comb begin
      err_res        = '0;
      err_res.status = 1'b1;
      new_res        = '0;
      new_res.side   = side_sel_ff;
      if (state_ff == S_WPUSH) begin
         new_res.x = midx_ff;
         new_res.y = midy_ff;
         new_res.z = midz_ff;
      end else begin
         new_res.x = pix_ff;
         new_res.y = piy_ff;
         new_res.z = piz_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         nx_ff         <= pps_pkg::ONE_Q16;
         ny_ff         <= '0;
         nz_ff         <= '0;
         pd_ff         <= '0;
         eps_ff        <= pps_pkg::EPS_W'(7);
         cnt_ff        <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               pps_pkg::CSR_NORMAL_X: nx_ff  <= csr_write_data[pps_pkg::NORM_W-1:0];
               pps_pkg::CSR_NORMAL_Y: ny_ff  <= csr_write_data[pps_pkg::NORM_W-1:0];
               pps_pkg::CSR_NORMAL_Z: nz_ff  <= csr_write_data[pps_pkg::NORM_W-1:0];
               pps_pkg::CSR_PLANE_D:  pd_ff  <= csr_write_data;
               pps_pkg::CSR_EPSILON:  eps_ff <= csr_write_data[pps_pkg::EPS_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (cnt_ff < CW'(MAX_VERTS)) begin
                     cnt_ff <= cnt_ff + CW'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_last_vertex) begin
                     idx_ff <= '0;
                     nf_ff  <= '0;
                     nb_ff  <= '0;
                     ncr_ff <= '0;
                     if (ovf_ff || cnt_ff >= CW'(MAX_VERTS)) begin
                        pend_ff       <= err_res;
                        pend_valid_ff <= 1'b1;
                        state_ff      <= S_FIN;
                     end else begin
                        state_ff <= S_CRD;
                     end
                  end
               end
            end
            S_CRD:  state_ff <= S_CCAP;
            S_CCAP: begin
               pix_ff   <= vtx_rd_ff[VW-1:2*CRW];
               piy_ff   <= vtx_rd_ff[2*CRW-1:CRW];
               piz_ff   <= vtx_rd_ff[CRW-1:0];
               state_ff <= S_CMX;
            end
            S_CMX: begin
               prod_ff  <= nx_ff * pix_ff;
               state_ff <= S_CMY;
            end
            S_CMY: begin
               acc_ff   <= DW'(prod_ff) - pd_shift;
               prod_ff  <= ny_ff * piy_ff;
               state_ff <= S_CMZ;
            end
            S_CMZ: begin
               acc_ff   <= acc_ff + DW'(prod_ff);
               prod_ff  <= nz_ff * piz_ff;
               state_ff <= S_CSUM;
            end
            S_CSUM: begin
               acc_ff   <= acc_ff + DW'(prod_ff);
               state_ff <= S_CCLS;
            end
            S_CCLS: begin
               if (cls_side == pps_pkg::SIDE_AHEAD) begin
                  nf_ff <= nf_ff + CW'(1);
               end
               if (cls_side == pps_pkg::SIDE_BEHIND) begin
                  nb_ff <= nb_ff + CW'(1);
               end
               if (idx_ff == '0) begin
                  first_side_ff <= cls_side;
               end
               prev_side_ff <= cls_side;
               if (idx_ff == idx_last) begin
                  ncr_ff <= ncr_ff
                     + CW'((idx_ff != '0) && (cls_side != pps_pkg::SIDE_ON) &&
                           (prev_side_ff != pps_pkg::SIDE_ON) &&
                           (prev_side_ff != cls_side))
                     + CW'((idx_ff != '0) && (cls_side != pps_pkg::SIDE_ON) &&
                           (first_side_ff != pps_pkg::SIDE_ON) &&
                           (first_side_ff != cls_side));
                  state_ff <= S_DECIDE;
               end else begin
                  ncr_ff <= ncr_ff
                     + CW'((idx_ff != '0) && (cls_side != pps_pkg::SIDE_ON) &&
                           (prev_side_ff != pps_pkg::SIDE_ON) &&
                           (prev_side_ff != cls_side));
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_CRD;
               end
            end
            S_DECIDE: begin
               idx_ff   <= '0;
               state_ff <= S_WRD_I;
               if (nf_ff == '0) begin
                  whole_ff    <= 1'b1;
                  side_sel_ff <= 1'b1;
               end else if (nb_ff == '0) begin
                  whole_ff    <= 1'b1;
                  side_sel_ff <= 1'b0;
               end else if ((KW'(ncr_ff) > KW'(nb_ff) + KW'(4)) ||
                            (KW'(ncr_ff) > KW'(nf_ff) + KW'(4))) begin
                  pend_ff       <= err_res;
                  pend_valid_ff <= 1'b1;
                  state_ff      <= S_FIN;
               end else begin
                  whole_ff    <= 1'b0;
                  side_sel_ff <= 1'b0;
               end
            end
            S_WRD_I: state_ff <= S_WCAP_I;
            S_WCAP_I: begin
               pix_ff   <= vtx_rd_ff[VW-1:2*CRW];
               piy_ff   <= vtx_rd_ff[2*CRW-1:CRW];
               piz_ff   <= vtx_rd_ff[CRW-1:0];
               pid_ff   <= dist_rd_ff[DW-1:0];
               si_ff    <= pps_pkg::side_type'(dist_rd_ff[SW-1:DW]);
               state_ff <= S_WCAP_J;
            end
            S_WCAP_J: begin
               pjx_ff   <= vtx_rd_ff[VW-1:2*CRW];
               pjy_ff   <= vtx_rd_ff[2*CRW-1:CRW];
               pjz_ff   <= vtx_rd_ff[CRW-1:0];
               pjd_ff   <= dist_rd_ff[DW-1:0];
               sj_ff    <= pps_pkg::side_type'(dist_rd_ff[SW-1:DW]);
               state_ff <= S_WVTX;
            end
            S_WVTX: begin
               if (!vtx_cond) begin
                  state_ff <= S_WCHK;
               end else if (can_produce) begin
                  if (pend_valid_ff) begin
                     rsp_ff       <= pend_ff;
                     rsp_last_ff  <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                  end
                  pend_ff       <= new_res;
                  pend_valid_ff <= 1'b1;
                  state_ff      <= S_WCHK;
               end
            end
            S_WCHK: begin
               state_ff <= cross_cond ? S_WDIV : S_WNEXT;
            end
            S_WDIV: begin
               if (div_done) begin
                  frac_ff  <= div_quot;
                  axis_ff  <= 2'd0;
                  state_ff <= S_WMUL;
               end
            end
            S_WMUL: begin
               mprod_ff <= {{CRW{1'b0}}, ax_mag} * {{(CRW+1){1'b0}}, frac_ff};
               msign_ff <= ax_diff[CRW];
               ax_p1_ff <= ax_p1;
               mnorm_ff <= ax_n;
               state_ff <= S_WCRD;
            end
            S_WCRD: begin
               case (axis_ff)
                  2'd0:    midx_ff <= mid_val;
                  2'd1:    midy_ff <= mid_val;
                  default: midz_ff <= mid_val;
               endcase
               if (axis_ff == 2'd2) begin
                  state_ff <= S_WPUSH;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_WMUL;
               end
            end
            S_WPUSH: begin
               if (can_produce) begin
                  if (pend_valid_ff) begin
                     rsp_ff       <= pend_ff;
                     rsp_last_ff  <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                  end
                  pend_ff       <= new_res;
                  pend_valid_ff <= 1'b1;
                  state_ff      <= S_WNEXT;
               end
            end
            S_WNEXT: begin
               if (idx_ff == idx_last) begin
                  if (!whole_ff && !side_sel_ff) begin
                     side_sel_ff <= 1'b1;
                     idx_ff      <= '0;
                     state_ff    <= S_WRD_I;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= S_WRD_I;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_ff        <= pend_ff;
                  rsp_last_ff   <= 1'b1;
                  rsp_valid_ff  <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  cnt_ff        <= '0;
                  ovf_ff        <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_ff.x;
   assign rsp_out_y       = rsp_ff.y;
   assign rsp_out_z       = rsp_ff.z;
   assign rsp_which_side  = rsp_ff.side;
   assign rsp_status      = rsp_ff.status;
   assign rsp_last_result = rsp_last_ff;

endmodule

FILE: rtl/core/pps_checker.sv
// ----------------------------------------------------------------------------
// Polygon plane split port checker
// Port level assertions on the split core, attached by bind.
// ----------------------------------------------------------------------------
`include "polygon_plane_split_core_macros.svh"

module pps_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_last_vertex,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [pps_pkg::COORD_W-1:0]   rsp_out_x,
   input logic signed [pps_pkg::COORD_W-1:0]   rsp_out_y,
   input logic signed [pps_pkg::COORD_W-1:0]   rsp_out_z,
   input logic                                 rsp_which_side,
   input logic                                 rsp_status,
   input logic                                 rsp_last_result
);

   `PPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   `PPS_ASSERT_NOW(a_err_last, clock, reset, rsp_valid && rsp_status, rsp_last_result, "error result not marked last")

   `PPS_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_status, rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0 && !rsp_which_side, "error result carries data")

   `PPS_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_last_vertex, !req_ready, "input taken during split")

endmodule

bind polygon_plane_split_core pps_checker u_pps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_last_vertex (req_last_vertex),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_x       (rsp_out_x),
   .rsp_out_y       (rsp_out_y),
   .rsp_out_z       (rsp_out_z),
   .rsp_which_side  (rsp_which_side),
   .rsp_status      (rsp_status),
   .rsp_last_result (rsp_last_result)
);
